// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the delimiter balance checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, disabled while reset is active.
`define DBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication that must hold in the cycle after its trigger.
`define DBC_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dbc_pkg.sv
// Types, constants and decode helpers for the delimiter balance checker.
package dbc_pkg;

  // Depth of the delimiter stack and the widths that follow from it.
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);

  // Character codes that the checker reacts to.
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  // Document status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_UNBAL    = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_UNTERM   = 3'd4,
    ST_NOSEL    = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_e;

  // Delimiter kinds as stored on the stack.
  typedef enum logic [1:0] {
    KIND_BRACE   = 2'd0,
    KIND_PAREN   = 2'd1,
    KIND_BRACKET = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  // Input beat: one document byte and its last-byte mark.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } dbc_in_t;

  // Output beat: the document status and the depth left open.
  typedef struct packed {
    status_e    status;
    logic [6:0] open_depth;
  } dbc_out_t;

  // Whitespace is space and the control bytes from tab to carriage return.
  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic kind_e open_kind(input logic [7:0] b);
    kind_e k;
    case (b)
      CH_LBRACE:   k = KIND_BRACE;
      CH_LPAREN:   k = KIND_PAREN;
      CH_LBRACKET: k = KIND_BRACKET;
      default:     k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_e close_kind(input logic [7:0] b);
    kind_e k;
    case (b)
      CH_RBRACE:   k = KIND_BRACE;
      CH_RPAREN:   k = KIND_PAREN;
      CH_RBRACKET: k = KIND_BRACKET;
      default:     k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// File: hw/rtl/delimiter_balance_checker_top.sv
// Delimiter balance checker: byte stream in, one status beat per document out.
// Throughput: one byte per cycle, unless a result beat waits unaccepted; the stack memory is
// read every cycle one entry below the top. The status beat is registered on the last byte.
// The output register releases its beat and takes the next one in the same cycle.
// Reset clears all control state; the stack memory is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module delimiter_balance_checker_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dbc_pkg::dbc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dbc_pkg::dbc_out_t out_data_o
);
  import dbc_pkg::*;

  // Control state.
  logic             in_comment_q, in_comment_d;
  logic             in_string_q, in_string_d;
  logic             escape_q, escape_d;
  logic [LVL_W-1:0] stack_level_q, stack_level_d;
  status_e          first_err_q, first_err_d;
  logic             saw_content_q, saw_content_d;
  logic             saw_brace_q, saw_brace_d;

  // Top of stack is cached; the entry below it comes from the memory read port.
  kind_e            top_q, top_d;
  kind_e            below_q;

  // Stack memory and its ports.
  kind_e            stack_mem [STACK_DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  kind_e            mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [LVL_W-1:0] raddr_full;

  // Output register.
  logic             out_valid_q;
  dbc_out_t         out_data_q, out_data_d;

  logic             in_acc;
  logic [7:0]       b;
  kind_e            ok_kind, ck_kind;
  status_e          status;
  logic [31:0]      level_wide;

  // Pre-clear copies of the state that feeds the status.
  status_e          first_err_pre;
  logic             in_string_pre;
  logic [LVL_W-1:0] level_pre;
  logic             brace_pre;
  logic             content_pre;

  // Signals watched by the checks.
  logic             doc_end;
  logic [LVL_W+2:0] stack_state;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign b          = in_data_i.byte_value;
  assign ok_kind    = open_kind(b);
  assign ck_kind    = close_kind(b);

  // Per-byte update of the scanner flags and the stack.
  always_comb begin
    in_comment_d  = in_comment_q;
    in_string_d   = in_string_q;
    escape_d      = escape_q;
    stack_level_d = stack_level_q;
    first_err_d   = first_err_q;
    saw_content_d = saw_content_q;
    saw_brace_d   = saw_brace_q;
    top_d         = top_q;
    mem_we        = 1'b0;
    mem_waddr     = stack_level_q[IDX_W-1:0];
    mem_wdata     = ok_kind;

    if (in_acc) begin
      if (in_comment_q) begin
        if (b == CH_NEWLINE) begin
          in_comment_d = 1'b0;
        end
      end else if (in_string_q) begin
        if (!is_space(b)) begin
          saw_content_d = 1'b1;
        end
        if (b == CH_LBRACE) begin
          saw_brace_d = 1'b1;
        end
        if (escape_q) begin
          escape_d = 1'b0;
        end else if (b == CH_BACKSLASH) begin
          escape_d = 1'b1;
        end else if (b == CH_QUOTE) begin
          in_string_d = 1'b0;
        end
      end else if (b == CH_HASH) begin
        in_comment_d = 1'b1;
      end else begin
        if (!is_space(b)) begin
          saw_content_d = 1'b1;
        end
        if (b == CH_QUOTE) begin
          in_string_d = 1'b1;
        end else begin
          if (b == CH_LBRACE) begin
            saw_brace_d = 1'b1;
          end
          // The stack freezes once an error is recorded.
          if (first_err_q == ST_OK) begin
            if (ok_kind != KIND_NONE) begin
              if (stack_level_q >= LVL_W'(STACK_DEPTH)) begin
                first_err_d = ST_OVERFLOW;
              end else begin
                mem_we        = 1'b1;
                top_d         = ok_kind;
                stack_level_d = stack_level_q + LVL_W'(1);
              end
            end else if (ck_kind != KIND_NONE) begin
              if (stack_level_q == '0) begin
                first_err_d = ST_UNBAL;
              end else begin
                stack_level_d = stack_level_q - LVL_W'(1);
                top_d         = below_q;
                if (top_q != ck_kind) begin
                  first_err_d = ST_MISMATCH;
                end
              end
            end
          end
        end
      end

      // The last byte returns the scanner to its reset state.
      if (in_data_i.last_byte) begin
        in_comment_d  = 1'b0;
        in_string_d   = 1'b0;
        escape_d      = 1'b0;
        stack_level_d = '0;
        first_err_d   = ST_OK;
        saw_content_d = 1'b0;
        saw_brace_d   = 1'b0;
      end
    end
  end

  // State after the current byte, before the end-of-document clear.
  always_comb begin
    first_err_pre = first_err_q;
    in_string_pre = in_string_q;
    level_pre     = stack_level_q;
    brace_pre     = saw_brace_q;
    content_pre   = saw_content_q;
    if (!in_comment_q) begin
      if (in_string_q) begin
        if (!is_space(b)) begin
          content_pre = 1'b1;
        end
        if (b == CH_LBRACE) begin
          brace_pre = 1'b1;
        end
        if (!escape_q && b == CH_QUOTE) begin
          in_string_pre = 1'b0;
        end
      end else if (b != CH_HASH) begin
        if (!is_space(b)) begin
          content_pre = 1'b1;
        end
        if (b == CH_QUOTE) begin
          in_string_pre = 1'b1;
        end else begin
          if (b == CH_LBRACE) begin
            brace_pre = 1'b1;
          end
          if (first_err_q == ST_OK) begin
            if (ok_kind != KIND_NONE) begin
              if (stack_level_q >= LVL_W'(STACK_DEPTH)) begin
                first_err_pre = ST_OVERFLOW;
              end else begin
                level_pre = stack_level_q + LVL_W'(1);
              end
            end else if (ck_kind != KIND_NONE) begin
              if (stack_level_q == '0) begin
                first_err_pre = ST_UNBAL;
              end else begin
                level_pre = stack_level_q - LVL_W'(1);
                if (top_q != ck_kind) begin
                  first_err_pre = ST_MISMATCH;
                end
              end
            end
          end
        end
      end
    end
  end

  // Final status, taken from the state after the last byte.
  always_comb begin
    status = ST_OK;
    if (!content_pre) begin
      status = ST_EMPTY;
    end else if (first_err_pre != ST_OK) begin
      status = first_err_pre;
    end else if (in_string_pre) begin
      status = ST_UNTERM;
    end else if (level_pre != '0) begin
      status = ST_UNBAL;
    end else if (!brace_pre) begin
      status = ST_NOSEL;
    end
  end

  // Output beat contents.
  always_comb begin
    level_wide            = 32'(level_pre);
    out_data_d.status     = status;
    out_data_d.open_depth = (level_wide > 32'd127) ? 7'd127 : level_wide[6:0];
  end

  // Read one entry below the next top so a pop finds its successor ready.
  assign raddr_full = stack_level_d - LVL_W'(2);
  assign mem_raddr  = raddr_full[IDX_W-1:0];

  // Stack memory: at most one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    below_q <= stack_mem[mem_raddr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_comment_q  <= 1'b0;
      in_string_q   <= 1'b0;
      escape_q      <= 1'b0;
      stack_level_q <= '0;
      first_err_q   <= ST_OK;
      saw_content_q <= 1'b0;
      saw_brace_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      in_comment_q  <= in_comment_d;
      in_string_q   <= in_string_d;
      escape_q      <= escape_d;
      stack_level_q <= stack_level_d;
      first_err_q   <= first_err_d;
      saw_content_q <= saw_content_d;
      saw_brace_q   <= saw_brace_d;
      if (in_acc && in_data_i.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (in_acc && in_data_i.last_byte) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign doc_end     = in_acc && in_data_i.last_byte;
  assign stack_state = {first_err_q, stack_level_q};

  // Checks on the stack and the end-of-document handling.
  `DBC_ASSERT(a_level_bound, stack_level_q <= LVL_W'(STACK_DEPTH), "stack level beyond depth")
  `DBC_ASSERT_NEXT(a_doc_end, doc_end, out_valid_q && stack_state == '0, "state not cleared")
  `DBC_ASSERT_NEXT(a_err_sticky, err_hold, $stable(stack_state), "state moved after error")

  logic err_hold;
  assign err_hold = (first_err_q != ST_OK) && !doc_end;

endmodule

// File: tb/delimiter_balance_checker_top_tb.sv
// Self-checking testbench: streams query documents into the delimiter balance checker.
module delimiter_balance_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BEATS = 1750;
  localparam int unsigned HOLD_CYCLES  = 400;

  localparam logic [7:0] OPEN_CH [3]    = '{CH_LBRACE, CH_LPAREN, CH_LBRACKET};
  localparam logic [7:0] CLOSE_CH [3]   = '{CH_RBRACE, CH_RPAREN, CH_RBRACKET};
  localparam logic [7:0] WS_CH [6]      = '{CH_SPACE, CH_TAB, CH_NEWLINE, 8'h0B, 8'h0C, CH_CR};
  localparam logic [7:0] SPECIAL_CH [9] = '{CH_LBRACE, CH_LPAREN, CH_LBRACKET, CH_RBRACE,
                                            CH_RPAREN, CH_RBRACKET, CH_QUOTE, CH_HASH,
                                            CH_BACKSLASH};

  // One row of the directed stimulus, with an optional hand-written result.
  typedef struct {
    dbc_in_t  beat;
    bit       typed;
    dbc_out_t res;
  } row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_r;
  logic      in_ready_o;
  dbc_in_t   in_data_r;
  logic      out_valid_o;
  logic      out_ready_r;
  dbc_out_t  out_data_o;

  dbc_out_t   pending_status_q [$];
  row_t       directed_rows [$];
  logic [7:0] doc_bytes [$];
  int         err_cnt = 0;
  int         live_beats = 0;
  bit         steady = 1'b0;

  // Shadow copy of the checker's scan state.
  logic        cmt_q;
  logic        str_q;
  logic        esc_q;
  int unsigned lvl_q;
  kind_e       kinds_q [STACK_DEPTH];
  status_e     err_q;
  logic        content_q;
  logic        brace_q;

  always #1 clk_i = ~clk_i;

  delimiter_balance_checker_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_r),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_r),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_r),
    .out_data_o (out_data_o)
  );

  function automatic void clear_scan();
    cmt_q     = 1'b0;
    str_q     = 1'b0;
    esc_q     = 1'b0;
    lvl_q     = 0;
    err_q     = ST_OK;
    content_q = 1'b0;
    brace_q   = 1'b0;
  endfunction

  // Append one byte to the document under construction.
  function automatic void put_byte(input logic [7:0] c);
    doc_bytes.insert(doc_bytes.size(), c);
  endfunction

  // Remove and return the newest entry of a kind list.
  function automatic int pull_last(ref int q[$]);
    int v;
    v = q[q.size() - 1];
    q.delete(q.size() - 1);
    return v;
  endfunction

  // Advance the shadow state by one byte; returns 1 with the status on the last byte.
  function automatic bit scan_byte(input dbc_in_t beat, output dbc_out_t res);
    logic [7:0] b;
    logic       blank;
    int         ko;
    int         kc;
    status_e    st;
    res   = '0;
    b     = beat.byte_value;
    blank = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    ko    = 3;
    kc    = 3;
    for (int k = 0; k < 3; k++) begin
      if (b == OPEN_CH[k]) ko = k;
      if (b == CLOSE_CH[k]) kc = k;
    end
    if (cmt_q) begin
      // Comments swallow everything up to the newline.
      if (b == CH_NEWLINE) cmt_q = 1'b0;
    end else if (str_q) begin
      if (!blank) content_q = 1'b1;
      if (b == CH_LBRACE) brace_q = 1'b1;
      if (esc_q) esc_q = 1'b0;
      else if (b == CH_BACKSLASH) esc_q = 1'b1;
      else if (b == CH_QUOTE) str_q = 1'b0;
    end else if (b == CH_HASH) begin
      cmt_q = 1'b1;
    end else begin
      if (!blank) content_q = 1'b1;
      if (b == CH_QUOTE) begin
        str_q = 1'b1;
      end else begin
        if (b == CH_LBRACE) brace_q = 1'b1;
        // The stack freezes once an error has been seen.
        if (err_q == ST_OK) begin
          if (ko != 3) begin
            if (lvl_q >= STACK_DEPTH) begin
              err_q = ST_OVERFLOW;
            end else begin
              kinds_q[lvl_q] = kind_e'(ko);
              lvl_q++;
            end
          end else if (kc != 3) begin
            if (lvl_q == 0) begin
              err_q = ST_UNBAL;
            end else begin
              lvl_q--;
              if (kinds_q[lvl_q] != kind_e'(kc)) err_q = ST_MISMATCH;
            end
          end
        end
      end
    end
    if (!beat.last_byte) return 1'b0;
    if (!content_q) st = ST_EMPTY;
    else if (err_q != ST_OK) st = err_q;
    else if (str_q) st = ST_UNTERM;
    else if (lvl_q != 0) st = ST_UNBAL;
    else if (!brace_q) st = ST_NOSEL;
    else st = ST_OK;
    res.status     = st;
    res.open_depth = (lvl_q > 127) ? 7'd127 : 7'(lvl_q);
    clear_scan();
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic last, input bit typed = 1'b0,
                                  input status_e st = ST_OK, input logic [6:0] depth = 7'd0);
    row_t r;
    r.beat.byte_value = b;
    r.beat.last_byte  = last;
    r.typed           = typed;
    r.res.status      = st;
    r.res.open_depth  = depth;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Balanced document with strings, comments, whitespace and identifiers.
  function automatic void add_well_formed();
    int         open_k [$];
    int         k;
    logic [7:0] c;
    if ($urandom_range(0, 9) != 0) begin
      put_byte(CH_LBRACE);
      open_k.insert(open_k.size(), 0);
    end
    repeat ($urandom_range(1, 24)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          if (open_k.size() < 10) begin
            k = $urandom_range(0, 2);
            put_byte(OPEN_CH[k]);
            open_k.insert(open_k.size(), k);
          end
        end
        2, 3: begin
          if (open_k.size() != 0) put_byte(CLOSE_CH[pull_last(open_k)]);
        end
        4: begin
          // Quoted string, sometimes with escapes of arbitrary bytes.
          put_byte(CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) begin
              put_byte(CH_BACKSLASH);
              put_byte(8'($urandom_range(0, 255)));
            end else begin
              c = 8'($urandom_range(8'h20, 8'h7E));
              put_byte((c == CH_QUOTE || c == CH_BACKSLASH) ? 8'h61 : c);
            end
          end
          put_byte(CH_QUOTE);
        end
        5: begin
          // Comment with arbitrary bytes, closed by a newline.
          put_byte(CH_HASH);
          repeat ($urandom_range(0, 8)) begin
            c = 8'($urandom_range(0, 255));
            put_byte((c == CH_NEWLINE) ? CH_SPACE : c);
          end
          put_byte(CH_NEWLINE);
        end
        6: put_byte(WS_CH[$urandom_range(0, 5)]);
        default: put_byte(8'($urandom_range(8'h61, 8'h7A)));
      endcase
    end
    while (open_k.size() != 0) put_byte(CLOSE_CH[pull_last(open_k)]);
  endfunction

  // Fill doc_bytes with one random document of a randomly chosen flavor.
  function automatic void build_document(input bit force_deep);
    int pick;
    int n;
    int k;
    int idx;
    int open_k [$];
    doc_bytes.delete();
    pick = force_deep ? 90 : $urandom_range(0, 99);
    if (pick < 75) begin
      add_well_formed();
      // Damaged documents: one or two edits to a balanced one.
      if (pick >= 55) begin
        if (doc_bytes.size() == 0) put_byte(CH_LBRACE);
        repeat ($urandom_range(1, 2)) begin
          idx = $urandom_range(0, doc_bytes.size() - 1);
          case ($urandom_range(0, 3))
            0: doc_bytes[idx] = SPECIAL_CH[$urandom_range(0, 8)];
            1: begin
              if (doc_bytes.size() > 1) doc_bytes.delete(idx);
            end
            2: put_byte(CLOSE_CH[$urandom_range(0, 2)]);
            default: doc_bytes.insert(idx, OPEN_CH[$urandom_range(0, 2)]);
          endcase
        end
      end
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(0, 255)));
    end else if (pick < 93) begin
      // Deep nesting around the stack limit, then partly or fully unwound.
      if (force_deep) n = STACK_DEPTH + 6;
      else if ($urandom_range(0, 2) == 0) n = STACK_DEPTH;
      else n = $urandom_range(56, 72);
      repeat (n) begin
        k = $urandom_range(0, 2);
        put_byte(OPEN_CH[k]);
        open_k.insert(open_k.size(), k);
      end
      repeat ($urandom_range(0, n)) put_byte(CLOSE_CH[pull_last(open_k)]);
    end else begin
      repeat ($urandom_range(1, 6)) put_byte(WS_CH[$urandom_range(0, 5)]);
      if ($urandom_range(0, 1) == 1) begin
        put_byte(CH_HASH);
        put_byte(CH_LBRACE);
      end
    end
  endfunction

  // Offer one beat, with random idle cycles first outside the steady phase, and record what it should produce.
  task automatic send_beat(input dbc_in_t beat, input bit typed, input dbc_out_t typed_res);
    dbc_out_t res;
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_valid_r <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_r <= 1'b1;
    in_data_r  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (scan_byte(beat, res)) begin
      pending_status_q.insert(pending_status_q.size(), typed ? typed_res : res);
    end
    live_beats++;
  endtask

  // Stimulus: directed rows, then random documents.
  initial begin : stimulus
    dbc_in_t  beat;
    dbc_out_t no_res;
    int       doc_n;
    rst_ni     = 1'b0;
    in_valid_r = 1'b0;
    in_data_r  = '0;
    no_res     = '0;
    clear_scan();

    // Close with an empty stack.
    add_row(CH_RBRACE, 1'b1, 1'b1, ST_UNBAL, 7'd0);
    // Whitespace only, both ends of the control range.
    add_row(CH_TAB, 1'b0);
    add_row(CH_CR, 1'b1, 1'b1, ST_EMPTY, 7'd0);
    // Smallest valid document.
    add_row(CH_LBRACE, 1'b0);
    add_row(CH_RBRACE, 1'b1);
    // Open delimiter left at the end.
    add_row(CH_LPAREN, 1'b1, 1'b1, ST_UNBAL, 7'd1);
    // Wrong close kind.
    add_row(CH_LPAREN, 1'b0);
    add_row(CH_RBRACKET, 1'b1, 1'b1, ST_MISMATCH, 7'd0);
    // An escaped quote keeps the string open.
    add_row(CH_QUOTE, 1'b0);
    add_row(CH_BACKSLASH, 1'b0);
    add_row(CH_QUOTE, 1'b1, 1'b1, ST_UNTERM, 7'd0);
    // A brace in a comment does not count; the newline ends the comment.
    add_row(CH_HASH, 1'b0);
    add_row(CH_LBRACE, 1'b0);
    add_row(CH_NEWLINE, 1'b0);
    add_row(8'h78, 1'b1, 1'b1, ST_NOSEL, 7'd0);
    // A brace in a string does count.
    add_row(CH_QUOTE, 1'b0);
    add_row(CH_LBRACE, 1'b0);
    add_row(CH_QUOTE, 1'b1);
    // Byte extremes.
    add_row(8'h00, 1'b1, 1'b1, ST_NOSEL, 7'd0);
    add_row(8'hFF, 1'b1, 1'b1, ST_NOSEL, 7'd0);
    // Mixed kinds side by side.
    add_row(CH_LBRACKET, 1'b0);
    add_row(CH_RBRACKET, 1'b0);
    add_row(CH_LBRACE, 1'b0);
    add_row(CH_RBRACE, 1'b1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].res);
    end

    // Random documents; the first one overflows the stack.
    live_beats = 0;
    doc_n      = 0;
    while (live_beats < RANDOM_BEATS) begin
      steady = (live_beats >= 400 && live_beats < 800);
      build_document(doc_n == 0);
      doc_n++;
      foreach (doc_bytes[i]) begin
        beat.byte_value = doc_bytes[i];
        beat.last_byte  = (i == doc_bytes.size() - 1);
        send_beat(beat, 1'b0, no_res);
      end
    end
    in_valid_r <= 1'b0;

    // Drain outstanding results, then a short quiet period.
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random back-pressure, one long hold, and checks on every beat.
  initial begin : drain
    int       hold_left;
    int       results_seen;
    bit       held;
    dbc_out_t want;
    hold_left    = 0;
    results_seen = 0;
    held         = 1'b0;
    out_ready_r  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_r) begin
        results_seen++;
        if (pending_status_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat: status %0d depth %0d", $time,
                   out_data_o.status, out_data_o.open_depth);
        end else begin
          want = pending_status_q.pop_front();
          if (out_data_o.status !== want.status) begin
            err_cnt++;
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     want.status, out_data_o.status);
          end
          if (out_data_o.open_depth !== want.open_depth) begin
            err_cnt++;
            $display("%0t: open_depth mismatch: expected %0d actual %0d", $time,
                     want.open_depth, out_data_o.open_depth);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_r <= 1'b0;
      end else if (!held && results_seen >= 25) begin
        held        = 1'b1;
        hold_left   = HOLD_CYCLES;
        out_ready_r <= 1'b0;
      end else begin
        out_ready_r <= steady || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // Watchdog on total run length.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: delimiter_balance_checker_top.f
+incdir+hw/rtl
hw/rtl/dbc_pkg.sv
hw/rtl/delimiter_balance_checker_top.sv
tb/delimiter_balance_checker_top_tb.sv
